>>> sv/tle_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the terminal line editor
package tle_pkg;

  localparam int LINE_MAX_DEFAULT = 128;
  // widest cell position for any supported line length
  localparam int POS_W = 9;

  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_ESC     = 8'h1b;
  localparam logic [7:0] CHAR_DEL     = 8'h7f;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_PRINT_HI = 8'h7e;
  localparam logic [7:0] CHAR_TILDE   = 8'h7e;
  localparam logic [7:0] CHAR_BRACKET = 8'h5b;
  localparam logic [7:0] CHAR_THREE   = 8'h33;
  localparam logic [7:0] CHAR_UP      = 8'h41;
  localparam logic [7:0] CHAR_DOWN    = 8'h42;
  localparam logic [7:0] CHAR_RIGHT   = 8'h43;
  localparam logic [7:0] CHAR_LEFT    = 8'h44;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_ECHO,
    ACT_RIGHT,
    ACT_LEFT,
    ACT_ERASE,
    ACT_REDRAW
  } echo_action_e;

  typedef enum logic [1:0] {
    ESC_IDLE,
    ESC_SEEN,
    ESC_BRACKET,
    ESC_THREE
  } esc_state_e;

  typedef enum logic {
    ST_IDLE,
    ST_TRIM
  } ctrl_state_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_SAVE,
    CELL_RECALL
  } cell_op_e;

  typedef struct packed {
    cell_op_e         op;
    logic [POS_W-1:0] pos;
    logic [7:0]       ch;
  } cell_cmd_t;

endpackage

>>> sv/tle_cell.sv
`timescale 1ns / 1ps
// one position of the line buffer and of the history buffer
module tle_cell #(
  parameter int INDEX = 0
) (
  input  logic                clk_i,
  input  tle_pkg::cell_cmd_t  cmd_i,
  input  logic [7:0]          left_i,
  input  logic [7:0]          right_i,
  output logic [7:0]          line_o
);

  localparam int PW = tle_pkg::POS_W;
  localparam logic [PW-1:0] IDX = PW'(INDEX);

  logic [7:0] line_q, line_d;
  logic [7:0] hist_q, hist_d;

  always_comb begin
    line_d = line_q;
    hist_d = hist_q;
    unique case (cmd_i.op)
      tle_pkg::CELL_INSERT: begin
        if (IDX == cmd_i.pos) begin
          line_d = cmd_i.ch;
        end else if (IDX > cmd_i.pos) begin
          line_d = left_i;
        end
      end
      tle_pkg::CELL_REMOVE: begin
        if (IDX >= cmd_i.pos) begin
          line_d = right_i;
        end
      end
      tle_pkg::CELL_SAVE:   hist_d = line_q;
      tle_pkg::CELL_RECALL: line_d = hist_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    line_q <= line_d;
    hist_q <= hist_d;
  end

  assign line_o = line_q;

endmodule

>>> sv/tle_ctrl.sv
`timescale 1ns / 1ps
// escape decoding, cursor and length tracking, trim sequencer and result register
module tle_ctrl #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEFAULT
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        cmd_i,
  input  logic [7:0]                  rx_char_i,
  input  logic [6:0]                  read_index_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tle_pkg::echo_action_e       echo_action_o,
  output logic [7:0]                  echo_char_o,
  output logic                        line_done_o,
  output logic [7:0]                  line_length_o,
  output logic [7:0]                  cursor_pos_o,
  output logic [7:0]                  read_char_o,
  output tle_pkg::cell_cmd_t          cell_cmd_o,
  output logic [$clog2(LINE_MAX)-1:0] rd_addr_o,
  input  logic [7:0]                  rd_byte_i
);

  localparam int LW = $clog2(LINE_MAX + 1);
  localparam int IW = $clog2(LINE_MAX);
  localparam int EW = (LW > 8) ? LW : 8;
  localparam int PW = tle_pkg::POS_W;
  localparam logic [LW-1:0] MAX_LEN = LW'(LINE_MAX);

  tle_pkg::ctrl_state_e  state_q, state_d;
  tle_pkg::esc_state_e   esc_q, esc_d, esc_e;
  logic [LW-1:0]         len_q, len_d, len_e;
  logic [LW-1:0]         cur_q, cur_d, cur_e;
  logic [LW-1:0]         hist_len_q, hist_len_d;
  logic                  complete_q, complete_d;

  logic                  out_valid_q, out_valid_d;
  tle_pkg::echo_action_e out_act_q, out_act_d;
  logic [7:0]            out_echo_q, out_echo_d;
  logic                  out_done_q, out_done_d;
  logic [7:0]            out_len_q, out_len_d;
  logic [7:0]            out_cur_q, out_cur_d;
  logic [7:0]            out_rd_q, out_rd_d;

  logic                  accept;
  logic                  load;
  logic                  trim_end;
  logic                  clear_line;
  logic [EW-1:0]         len_x, cur_x;

  assign in_ready_o = (state_q == tle_pkg::ST_IDLE) && (!out_valid_q || out_ready_i);
  assign accept     = in_valid_i && in_ready_o;
  assign trim_end   = (len_q == '0) || (rd_byte_i != tle_pkg::CHAR_SPACE);
  // a completed line is emptied by the next terminal byte
  assign clear_line = !cmd_i && complete_q;
  assign len_e      = clear_line ? '0 : len_q;
  assign cur_e      = clear_line ? '0 : cur_q;
  assign esc_e      = clear_line ? tle_pkg::ESC_IDLE : esc_q;
  assign len_x      = EW'(len_d);
  assign cur_x      = EW'(cur_d);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tle_pkg::ST_IDLE: begin
        if (accept && !cmd_i && rx_char_i == tle_pkg::CHAR_CR) begin
          state_d = tle_pkg::ST_TRIM;
        end
      end
      tle_pkg::ST_TRIM: begin
        if (trim_end) begin
          state_d = tle_pkg::ST_IDLE;
        end
      end
      default: state_d = tle_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    esc_d      = esc_q;
    len_d      = len_q;
    cur_d      = cur_q;
    hist_len_d = hist_len_q;
    complete_d = complete_q;
    load       = 1'b0;
    out_act_d  = tle_pkg::ACT_NONE;
    out_echo_d = '0;
    out_done_d = 1'b0;
    out_rd_d   = '0;
    cell_cmd_o = '{op: tle_pkg::CELL_HOLD, pos: '0, ch: '0};
    rd_addr_o  = IW'(read_index_i);

    unique case (state_q)
      tle_pkg::ST_IDLE: begin
        if (accept && cmd_i) begin
          load = 1'b1;
          if (EW'(read_index_i) < EW'(len_q)) begin
            out_rd_d = rd_byte_i;
          end
        end else if (accept) begin
          load = 1'b1;
          if (clear_line) begin
            complete_d = 1'b0;
          end
          len_d = len_e;
          cur_d = cur_e;
          esc_d = esc_e;
          if (rx_char_i == tle_pkg::CHAR_CR) begin
            // result comes at the end of the trim pass
            load  = 1'b0;
            esc_d = tle_pkg::ESC_IDLE;
          end else if (rx_char_i == tle_pkg::CHAR_ESC) begin
            esc_d = tle_pkg::ESC_SEEN;
          end else if (esc_e == tle_pkg::ESC_SEEN && rx_char_i == tle_pkg::CHAR_BRACKET) begin
            esc_d = tle_pkg::ESC_BRACKET;
          end else if (esc_e == tle_pkg::ESC_BRACKET && rx_char_i == tle_pkg::CHAR_THREE) begin
            esc_d = tle_pkg::ESC_THREE;
          end else if (esc_e == tle_pkg::ESC_THREE && rx_char_i == tle_pkg::CHAR_TILDE) begin
            esc_d = tle_pkg::ESC_IDLE;
            if (cur_e < len_e) begin
              cell_cmd_o = '{op: tle_pkg::CELL_REMOVE, pos: PW'(cur_e), ch: '0};
              len_d      = len_e - LW'(1);
            end
          end else if (esc_e == tle_pkg::ESC_BRACKET && rx_char_i == tle_pkg::CHAR_RIGHT) begin
            esc_d = tle_pkg::ESC_IDLE;
            if (cur_e < len_e) begin
              cur_d     = cur_e + LW'(1);
              out_act_d = tle_pkg::ACT_RIGHT;
            end
          end else if (esc_e == tle_pkg::ESC_BRACKET && rx_char_i == tle_pkg::CHAR_LEFT) begin
            esc_d = tle_pkg::ESC_IDLE;
            if (cur_e != '0) begin
              cur_d     = cur_e - LW'(1);
              out_act_d = tle_pkg::ACT_LEFT;
            end
          end else if (esc_e == tle_pkg::ESC_BRACKET && rx_char_i == tle_pkg::CHAR_UP) begin
            esc_d = tle_pkg::ESC_IDLE;
            if (hist_len_q != '0) begin
              cell_cmd_o = '{op: tle_pkg::CELL_RECALL, pos: '0, ch: '0};
              len_d      = hist_len_q;
              cur_d      = hist_len_q;
              out_act_d  = tle_pkg::ACT_REDRAW;
            end
          end else if (esc_e == tle_pkg::ESC_BRACKET && rx_char_i == tle_pkg::CHAR_DOWN) begin
            esc_d = tle_pkg::ESC_IDLE;
          end else if (rx_char_i == tle_pkg::CHAR_DEL) begin
            // backspace leaves a pending escape as it is
            if (cur_e != '0) begin
              cell_cmd_o = '{op: tle_pkg::CELL_REMOVE, pos: PW'(cur_e - LW'(1)), ch: '0};
              cur_d      = cur_e - LW'(1);
              len_d      = len_e - LW'(1);
              out_act_d  = tle_pkg::ACT_ERASE;
            end
          end else if (rx_char_i >= tle_pkg::CHAR_SPACE && rx_char_i <= tle_pkg::CHAR_PRINT_HI
                       && cur_e < MAX_LEN && esc_e == tle_pkg::ESC_IDLE) begin
            // on a full line the last byte falls off the end of the chain
            cell_cmd_o = '{op: tle_pkg::CELL_INSERT, pos: PW'(cur_e), ch: rx_char_i};
            cur_d      = cur_e + LW'(1);
            if (len_e < MAX_LEN) begin
              len_d = len_e + LW'(1);
            end
            out_act_d  = tle_pkg::ACT_ECHO;
            out_echo_d = rx_char_i;
          end else begin
            esc_d = tle_pkg::ESC_IDLE;
          end
        end
      end
      tle_pkg::ST_TRIM: begin
        rd_addr_o = IW'(len_q - LW'(1));
        if (!trim_end) begin
          len_d = len_q - LW'(1);
        end else begin
          load       = 1'b1;
          out_done_d = 1'b1;
          complete_d = 1'b1;
          if (cur_q > len_q) begin
            cur_d = len_q;
          end
          if (len_q != '0) begin
            cell_cmd_o = '{op: tle_pkg::CELL_SAVE, pos: '0, ch: '0};
            hist_len_d = len_q;
          end
        end
      end
      default: ;
    endcase

    out_len_d = len_x[7:0];
    out_cur_d = cur_x[7:0];
  end

  assign out_valid_d = load || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tle_pkg::ST_IDLE;
      esc_q       <= tle_pkg::ESC_IDLE;
      len_q       <= '0;
      cur_q       <= '0;
      hist_len_q  <= '0;
      complete_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      esc_q       <= esc_d;
      len_q       <= len_d;
      cur_q       <= cur_d;
      hist_len_q  <= hist_len_d;
      complete_q  <= complete_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_act_q  <= out_act_d;
      out_echo_q <= out_echo_d;
      out_done_q <= out_done_d;
      out_len_q  <= out_len_d;
      out_cur_q  <= out_cur_d;
      out_rd_q   <= out_rd_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign echo_action_o = out_act_q;
  assign echo_char_o   = out_echo_q;
  assign line_done_o   = out_done_q;
  assign line_length_o = out_len_q;
  assign cursor_pos_o  = out_cur_q;
  assign read_char_o   = out_rd_q;

endmodule

>>> sv/terminal_line_editor.sv
`timescale 1ns / 1ps
// Terminal line editor: edits a line buffer with a cursor from received terminal bytes.
//
// Input stream: s_axis_tuser selects the command (0 terminal byte, 1 read a line byte),
// s_axis_tdata carries the byte and the read position. Every input transaction gives
// exactly one output transaction with an echo action, the line length, the cursor and
// the byte read. m_axis_tlast flags the result that completes a line.
// The buffer is a row of cells, one per position; inserts, deletes and history copies
// move the whole row at once.
// A read or an ordinary byte gives its result from the output register in the cycle after
// the transaction, and a new transaction can be taken as soon as the receiver takes that
// result. A carriage return walks the trailing spaces back one per cycle through the read
// mux: its result is registered at the end of the trim pass, and no input is taken
// meanwhile.
// Reset empties the line and the history, homes the cursor and drops any pending escape;
// buffer contents are not cleared. When the receiver stalls, the result waits in the output
// register and the input side is held off until it is taken.
module terminal_line_editor #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEFAULT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // rx_char[7:0], read_index[14:8], zero [15]
  input  logic        s_axis_tuser,  // cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,  // echo_char[7:0], line_length[15:8], cursor_pos[23:16],
                                     // read_char[31:24]
  output logic [2:0]  m_axis_tuser,  // echo_action
  output logic        m_axis_tlast   // line_done
);

  localparam int IW = $clog2(LINE_MAX);

  tle_pkg::cell_cmd_t    cell_cmd;
  tle_pkg::echo_action_e echo_action;
  logic [IW-1:0]         rd_addr;
  logic [7:0]            rd_byte;
  logic [7:0]            line_w [LINE_MAX];
  logic [7:0]            echo_char;
  logic [7:0]            line_length;
  logic [7:0]            cursor_pos;
  logic [7:0]            read_char;

  tle_ctrl #(
    .LINE_MAX(LINE_MAX)
  ) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i    (s_axis_tvalid),
    .in_ready_o    (s_axis_tready),
    .cmd_i         (s_axis_tuser),
    .rx_char_i     (s_axis_tdata[7:0]),
    .read_index_i  (s_axis_tdata[14:8]),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .echo_action_o (echo_action),
    .echo_char_o   (echo_char),
    .line_done_o   (m_axis_tlast),
    .line_length_o (line_length),
    .cursor_pos_o  (cursor_pos),
    .read_char_o   (read_char),
    .cell_cmd_o    (cell_cmd),
    .rd_addr_o     (rd_addr),
    .rd_byte_i     (rd_byte)
  );

  for (genvar g = 0; g < LINE_MAX; g++) begin : g_cell
    logic [7:0] left_w;
    logic [7:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = 8'h00;
    end else begin : g_inner_l
      assign left_w = line_w[g-1];
    end
    if (g == LINE_MAX - 1) begin : g_last
      assign right_w = line_w[g];
    end else begin : g_inner_r
      assign right_w = line_w[g+1];
    end
    tle_cell #(
      .INDEX(g)
    ) u_cell (
      .clk_i,
      .cmd_i   (cell_cmd),
      .left_i  (left_w),
      .right_i (right_w),
      .line_o  (line_w[g])
    );
  end

  // single read port, shared by read commands and the trim pass
  assign rd_byte = line_w[rd_addr];

  assign m_axis_tuser = echo_action;
  assign m_axis_tdata = {read_char, cursor_pos, line_length, echo_char};

endmodule

>>> sv/tle_checker.sv
`timescale 1ns / 1ps
// port-level checks of the terminal line editor and their binding
module tle_checker #(
  parameter int LINE_MAX = tle_pkg::LINE_MAX_DEFAULT
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // a waiting result holds still
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  // one item in flight: no input while a result is stuck
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while result stalled");

  // a completed line never echoes anything
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == tle_pkg::ACT_NONE)
    else $error("line completion with echo action");

  // echoed bytes are printable, no echo byte otherwise
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser == tle_pkg::ACT_ECHO)
      ? (m_axis_tdata[7:0] >= tle_pkg::CHAR_SPACE && m_axis_tdata[7:0] <= tle_pkg::CHAR_PRINT_HI)
      : (m_axis_tdata[7:0] == 8'h00))
    else $error("bad echo byte");

  // cursor never passes the end of the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (LINE_MAX < 256) |-> m_axis_tdata[23:16] <= m_axis_tdata[15:8])
    else $error("cursor beyond line length");

endmodule

bind terminal_line_editor tle_checker #(.LINE_MAX(LINE_MAX)) u_tle_checker (.*);
